// ===== rtl/core/obdtp_pkg.sv =====
// ----------------------------------------------------------------------------
// OBD ISO-TP request receiver package
// Shared widths, codes, reset values and frame constants.
// ----------------------------------------------------------------------------
package obdtp_pkg;

	localparam int ID_W   = 11;
	localparam int DATA_W = 64;
	localparam int LEN_W  = 12;
	localparam int TMO_W  = 16;
	localparam int ADDR_W = 4;
	localparam int APB_W  = 32;

	// command codes of an input item
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_FRAME = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// done status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SEQ     = 2'd1;
	localparam logic [1:0] ST_TYPE    = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_REQUEST_ID    = 2'd0;
	localparam logic [1:0] REG_RESPONSE_ID   = 2'd1;
	localparam logic [1:0] REG_IDLE_TIMEOUT  = 2'd2;
	localparam logic [1:0] REG_TOTAL_TIMEOUT = 2'd3;

	// register reset values
	localparam logic [ID_W-1:0]  REQUEST_ID_RST    = 11'h7DF;
	localparam logic [ID_W-1:0]  RESPONSE_ID_RST   = 11'h7E8;
	localparam logic [TMO_W-1:0] IDLE_TIMEOUT_RST  = 16'd500;
	localparam logic [TMO_W-1:0] TOTAL_TIMEOUT_RST = 16'd5000;

	// frame constants
	localparam logic [7:0] PCI_QUERY     = 8'h02;
	localparam logic [7:0] PCI_FLOW_CTRL = 8'h30;
	localparam logic [7:0] PID_ANY       = 8'hFF;
	localparam logic [3:0] TYPE_SF       = 4'h0;
	localparam logic [3:0] TYPE_FF       = 4'h1;
	localparam logic [3:0] TYPE_CF       = 4'h2;
	localparam logic [2:0] MAX_FRAME_BYTES = 3'd7;
	localparam logic [2:0] FF_BYTES        = 3'd6;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_FIRST  = 3'b010,
		PH_CONSEC = 3'b100
	} phase_t;

endpackage

// ===== rtl/core/obdtp_item_if.sv =====
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface obdtp_item_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       cmd;
	logic [7:0]                       req_mode;
	logic [7:0]                       req_pid;
	logic [obdtp_pkg::ID_W-1:0]       frame_id;
	logic [obdtp_pkg::DATA_W-1:0]     frame_data;

	modport source (output valid, cmd, req_mode, req_pid, frame_id, frame_data, input ready);
	modport sink (input valid, cmd, req_mode, req_pid, frame_id, frame_data, output ready);
endinterface

// ===== rtl/core/obdtp_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface obdtp_res_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       kind;
	logic [obdtp_pkg::ID_W-1:0]       tx_id;
	logic [obdtp_pkg::DATA_W-1:0]     tx_data;
	logic [7:0]                       payload_byte;
	logic [1:0]                       status;
	logic [obdtp_pkg::LEN_W-1:0]      resp_len;
	logic                             last;

	modport source (output valid, kind, tx_id, tx_data, payload_byte, status,
		resp_len, last, input ready);
	modport sink (input valid, kind, tx_id, tx_data, payload_byte, status,
		resp_len, last, output ready);
endinterface

// ===== rtl/core/obd_isotp_request_receiver.sv =====
// ----------------------------------------------------------------------------
// OBD ISO-TP request receiver
// Requesting side of an OBD query: single-frame query out, response frames
// filtered and reassembled into payload bytes, flow control and a done status.
// ----------------------------------------------------------------------------
// Usage:
//  item   : valid/ready input. cmd start sends a query and opens a run, cmd
//           frame feeds one received CAN frame, cmd tick is one millisecond.
//  res    : valid/ready output, one result per transfer: a frame to send,
//           one payload byte, or the done status (last = 1) closing the run.
//  APB    : four registers at 0x0/0x4/0x8/0xC (request id, response id,
//           idle timeout, total timeout); write only while idle.
// Timing:
//  An accepted item updates the run state at once and loads a result batch
//  (payload bytes, then a transmit frame, then done) into the batch register.
//  The batch drains into the output register one result per cycle while the
//  output register is empty or res.ready is high, so the first result passes
//  the batch register and then the output register. item.ready is high while
//  the batch register is empty; an item without results leaves it empty.
//  The drain rate is set by the single output register.
// Reset clears the run state, the batch and the output valid; registers
// take their default ids and timeouts. When res.ready is low the current
// result holds, the batch stalls and item.ready stays low until it drains.
// ----------------------------------------------------------------------------
module obd_isotp_request_receiver (
	input  logic                             clk,
	input  logic                             arst_n,
	obdtp_item_if.sink                       item,
	obdtp_res_if.source                      res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [obdtp_pkg::ADDR_W-1:0]     paddr,
	input  logic [obdtp_pkg::APB_W-1:0]      pwdata,
	output logic [obdtp_pkg::APB_W-1:0]      prdata,
	output logic                             pready
);

	// pending results of one item, emitted in field order
	typedef struct packed {
		logic [obdtp_pkg::DATA_W-1:0] pl_data;  // frame carrying the payload bytes
		logic [2:0]                   pl_idx;   // next payload byte index
		logic [2:0]                   pl_cnt;   // payload bytes still to emit
		logic                         tx_en;
		logic [obdtp_pkg::ID_W-1:0]   tx_id;
		logic [obdtp_pkg::DATA_W-1:0] tx_data;
		logic                         done_en;
		logic [1:0]                   done_st;
		logic [obdtp_pkg::LEN_W-1:0]  done_len;
	} batch_t;

	// configuration
	logic [obdtp_pkg::ID_W-1:0]  request_id_q;
	logic [obdtp_pkg::ID_W-1:0]  response_id_q;
	logic [obdtp_pkg::TMO_W-1:0] idle_tmo_q;
	logic [obdtp_pkg::TMO_W-1:0] total_tmo_q;
	logic                        cfg_wr;

	// run state
	obdtp_pkg::phase_t           phase_q, phase_n;
	logic [7:0]                  pid_q, pid_n;
	logic [3:0]                  seq_q, seq_n;
	logic [obdtp_pkg::LEN_W-1:0] rcv_q, rcv_n;
	logic [obdtp_pkg::LEN_W-1:0] exp_q, exp_n;
	logic [obdtp_pkg::TMO_W-1:0] idle_q, idle_n;
	logic [obdtp_pkg::TMO_W-1:0] total_q, total_n;

	// batch and output
	batch_t                      bat_s1, bat_new, bat_n;
	logic                        bat_busy;
	logic                        move;
	logic                        accept;
	logic                        out_vld_q;

	// frame decode
	logic [7:0]                  pci, fb1, fb2;
	logic [3:0]                  ftype, fnib;
	logic [2:0]                  sf_len;
	logic [obdtp_pkg::LEN_W-1:0] ff_len;
	logic [obdtp_pkg::LEN_W-1:0] cf_rem;
	logic [2:0]                  cf_n;
	logic [obdtp_pkg::LEN_W-1:0] cf_sum;
	logic [obdtp_pkg::TMO_W-1:0] idle_inc, total_inc;
	logic [2:0]                  byte_sel;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_id_q  <= obdtp_pkg::REQUEST_ID_RST;
			response_id_q <= obdtp_pkg::RESPONSE_ID_RST;
			idle_tmo_q    <= obdtp_pkg::IDLE_TIMEOUT_RST;
			total_tmo_q   <= obdtp_pkg::TOTAL_TIMEOUT_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				obdtp_pkg::REG_REQUEST_ID:    request_id_q  <= pwdata[obdtp_pkg::ID_W-1:0];
				obdtp_pkg::REG_RESPONSE_ID:   response_id_q <= pwdata[obdtp_pkg::ID_W-1:0];
				obdtp_pkg::REG_IDLE_TIMEOUT:  idle_tmo_q    <= pwdata[obdtp_pkg::TMO_W-1:0];
				obdtp_pkg::REG_TOTAL_TIMEOUT: total_tmo_q   <= pwdata[obdtp_pkg::TMO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			obdtp_pkg::REG_REQUEST_ID:    prdata = {21'd0, request_id_q};
			obdtp_pkg::REG_RESPONSE_ID:   prdata = {21'd0, response_id_q};
			obdtp_pkg::REG_IDLE_TIMEOUT:  prdata = {16'd0, idle_tmo_q};
			obdtp_pkg::REG_TOTAL_TIMEOUT: prdata = {16'd0, total_tmo_q};
			default:                      prdata = '0;
		endcase
	end

	// new item enters only once the previous batch has fully drained
	assign bat_busy   = (bat_s1.pl_cnt != 3'd0) || bat_s1.tx_en || bat_s1.done_en;
	assign item.ready = !bat_busy;
	assign accept     = item.valid && !bat_busy;

	assign pci    = item.frame_data[63:56];
	assign fb1    = item.frame_data[55:48];
	assign fb2    = item.frame_data[47:40];
	assign ftype  = pci[7:4];
	assign fnib   = pci[3:0];
	assign sf_len = (fnib > {1'b0, obdtp_pkg::MAX_FRAME_BYTES}) ?
		obdtp_pkg::MAX_FRAME_BYTES : fnib[2:0];
	assign ff_len = {fnib, fb1};
	assign cf_rem = exp_q - rcv_q;
	assign cf_n   = (cf_rem > {9'd0, obdtp_pkg::MAX_FRAME_BYTES}) ?
		obdtp_pkg::MAX_FRAME_BYTES : cf_rem[2:0];
	assign cf_sum = rcv_q + {9'd0, cf_n};
	// counters saturate at all ones
	assign idle_inc  = (&idle_q)  ? idle_q  : idle_q + 16'd1;
	assign total_inc = (&total_q) ? total_q : total_q + 16'd1;

	// one pass of the protocol for the accepted item
	always_comb begin
		phase_n = phase_q;
		pid_n   = pid_q;
		seq_n   = seq_q;
		rcv_n   = rcv_q;
		exp_n   = exp_q;
		idle_n  = idle_q;
		total_n = total_q;
		bat_new = '0;
		bat_new.pl_data = item.frame_data;
		if (accept) begin
			case (item.cmd)
				obdtp_pkg::CMD_START: begin
					pid_n   = item.req_pid;
					phase_n = obdtp_pkg::PH_FIRST;
					seq_n   = '0;
					rcv_n   = '0;
					exp_n   = '0;
					idle_n  = '0;
					total_n = '0;
					bat_new.tx_en   = 1'b1;
					bat_new.tx_id   = request_id_q;
					bat_new.tx_data = {obdtp_pkg::PCI_QUERY, item.req_mode, item.req_pid, 40'd0};
				end
				obdtp_pkg::CMD_FRAME: begin
					if (phase_q != obdtp_pkg::PH_IDLE) begin
						idle_n = '0;
						if (item.frame_id == response_id_q) begin
							if (phase_q == obdtp_pkg::PH_FIRST) begin
								if (fb2 == pid_q || fb2 == obdtp_pkg::PID_ANY) begin
									total_n = '0;
									bat_new.done_en = 1'b1;
									phase_n = obdtp_pkg::PH_IDLE;
									case (ftype)
										obdtp_pkg::TYPE_SF: begin
											exp_n = {9'd0, sf_len};
											bat_new.pl_idx   = 3'd1;
											bat_new.pl_cnt   = sf_len;
											bat_new.done_st  = obdtp_pkg::ST_OK;
											bat_new.done_len = {9'd0, sf_len};
										end
										obdtp_pkg::TYPE_FF: begin
											exp_n = ff_len;
											rcv_n = {9'd0, obdtp_pkg::FF_BYTES};
											seq_n = 4'd1;
											bat_new.pl_idx   = 3'd2;
											bat_new.pl_cnt   = obdtp_pkg::FF_BYTES;
											bat_new.tx_en    = 1'b1;
											bat_new.tx_id    = request_id_q;
											bat_new.tx_data  = {obdtp_pkg::PCI_FLOW_CTRL, 56'd0};
											bat_new.done_st  = obdtp_pkg::ST_OK;
											bat_new.done_len = ff_len;
											// short first frame closes the run at once
											if (ff_len > {9'd0, obdtp_pkg::FF_BYTES}) begin
												bat_new.done_en = 1'b0;
												phase_n = obdtp_pkg::PH_CONSEC;
											end
										end
										default: begin
											exp_n = '0;
											bat_new.done_st  = obdtp_pkg::ST_TYPE;
											bat_new.done_len = '0;
										end
									endcase
								end
							end else begin
								total_n = '0;
								bat_new.done_len = exp_q;
								if (ftype != obdtp_pkg::TYPE_CF) begin
									bat_new.done_en = 1'b1;
									bat_new.done_st = obdtp_pkg::ST_TYPE;
									phase_n = obdtp_pkg::PH_IDLE;
								end else if (fnib != seq_q) begin
									bat_new.done_en = 1'b1;
									bat_new.done_st = obdtp_pkg::ST_SEQ;
									phase_n = obdtp_pkg::PH_IDLE;
								end else begin
									seq_n = seq_q + 4'd1;
									rcv_n = cf_sum;
									bat_new.pl_idx = 3'd1;
									bat_new.pl_cnt = cf_n;
									if (cf_sum >= exp_q) begin
										bat_new.done_en = 1'b1;
										bat_new.done_st = obdtp_pkg::ST_OK;
										phase_n = obdtp_pkg::PH_IDLE;
									end
								end
							end
						end
					end
				end
				obdtp_pkg::CMD_TICK: begin
					if (phase_q != obdtp_pkg::PH_IDLE) begin
						idle_n  = idle_inc;
						total_n = total_inc;
						if (idle_inc >= idle_tmo_q || total_inc >= total_tmo_q) begin
							bat_new.done_en  = 1'b1;
							bat_new.done_st  = obdtp_pkg::ST_TIMEOUT;
							bat_new.done_len = exp_q;
							phase_n = obdtp_pkg::PH_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// drain order: payload bytes, transmit frame, done
	assign move = bat_busy && (!out_vld_q || res.ready);

	always_comb begin
		bat_n = bat_s1;
		if (accept) begin
			bat_n = bat_new;
		end else if (move) begin
			if (bat_s1.pl_cnt != 3'd0) begin
				bat_n.pl_cnt = bat_s1.pl_cnt - 3'd1;
				bat_n.pl_idx = bat_s1.pl_idx + 3'd1;
			end else if (bat_s1.tx_en) begin
				bat_n.tx_en = 1'b0;
			end else begin
				bat_n.done_en = 1'b0;
			end
		end
	end

	assign byte_sel = 3'd7 - bat_s1.pl_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= obdtp_pkg::PH_IDLE;
			pid_q     <= '0;
			seq_q     <= '0;
			rcv_q     <= '0;
			exp_q     <= '0;
			idle_q    <= '0;
			total_q   <= '0;
			bat_s1    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			pid_q   <= pid_n;
			seq_q   <= seq_n;
			rcv_q   <= rcv_n;
			exp_q   <= exp_n;
			idle_q  <= idle_n;
			total_q <= total_n;
			bat_s1  <= bat_n;
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// output payload register, zero in fields that the kind does not use
	always_ff @(posedge clk) begin
		if (move) begin
			res.tx_id        <= '0;
			res.tx_data      <= '0;
			res.payload_byte <= '0;
			res.status       <= '0;
			res.resp_len     <= '0;
			res.last         <= 1'b0;
			if (bat_s1.pl_cnt != 3'd0) begin
				res.kind         <= obdtp_pkg::KIND_BYTE;
				res.payload_byte <= bat_s1.pl_data[{byte_sel, 3'b000} +: 8];
			end else if (bat_s1.tx_en) begin
				res.kind    <= obdtp_pkg::KIND_TX;
				res.tx_id   <= bat_s1.tx_id;
				res.tx_data <= bat_s1.tx_data;
			end else begin
				res.kind     <= obdtp_pkg::KIND_DONE;
				res.status   <= bat_s1.done_st;
				res.resp_len <= bat_s1.done_len;
				res.last     <= 1'b1;
			end
		end
	end

	assign res.valid = out_vld_q;

endmodule

// ===== rtl/core/obdtp_checker.sv =====
// ----------------------------------------------------------------------------
// OBD ISO-TP request receiver checker
// Port-level assertions on the result channel and APB port.
// ----------------------------------------------------------------------------
module obdtp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic [1:0]                       res_kind,
	input logic [obdtp_pkg::ID_W-1:0]       res_tx_id,
	input logic [obdtp_pkg::DATA_W-1:0]     res_tx_data,
	input logic [7:0]                       res_payload_byte,
	input logic                             res_last,
	input logic                             pready
);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// last marks exactly the done result
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_last == (res_kind == obdtp_pkg::KIND_DONE)))
		else $error("last does not match done kind");

	// transmit fields are clear on other kinds
	a_tx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != obdtp_pkg::KIND_TX |-> res_tx_id == '0 && res_tx_data == '0)
		else $error("transmit fields set on non-transmit result");

	// payload byte is clear on other kinds
	a_byte_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != obdtp_pkg::KIND_BYTE |-> res_payload_byte == 8'd0)
		else $error("payload byte set on non-byte result");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind obd_isotp_request_receiver obdtp_checker u_obdtp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_kind         (res.kind),
	.res_tx_id        (res.tx_id),
	.res_tx_data      (res.tx_data),
	.res_payload_byte (res.payload_byte),
	.res_last         (res.last),
	.pready           (pready)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// OBD ISO-TP request receiver testbench
// Sends query, frame and tick items with random gaps and stalls the result
// channel at random. A predictor tracks the run state and the registers, and
// every result transfer is checked field by field against its expectation.
// ----------------------------------------------------------------------------
module tb;
	import obdtp_pkg::*;

	// cmd value with no meaning, the block must ignore it
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// flow-control frame type, not valid as a response frame
	localparam logic [3:0] TYPE_FC    = 4'h3;

	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_PRINTED   = 40;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ID_W-1:0]   tx_id;
		logic [DATA_W-1:0] tx_data;
		logic [7:0]        payload_byte;
		logic [1:0]        status;
		logic [LEN_W-1:0]  resp_len;
		logic              last;
	} result_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_W-1:0]  pwdata;
	logic [APB_W-1:0]  prdata;
	logic              pready;

	obdtp_item_if item_ch();
	obdtp_res_if  res_ch();

	obd_isotp_request_receiver dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// ------------------------------------------------------------------------
	// Predicted block state: register copies and the open run
	// ------------------------------------------------------------------------
	logic [ID_W-1:0]  cfg_request_id  = REQUEST_ID_RST;
	logic [ID_W-1:0]  cfg_response_id = RESPONSE_ID_RST;
	logic [TMO_W-1:0] cfg_idle_limit  = IDLE_TIMEOUT_RST;
	logic [TMO_W-1:0] cfg_total_limit = TOTAL_TIMEOUT_RST;

	phase_t           run_phase     = PH_IDLE;
	logic [7:0]       run_pid       = '0;
	logic [3:0]       next_seq      = '0;
	logic [LEN_W-1:0] rx_count      = '0;
	logic [LEN_W-1:0] announced_len = '0;
	logic [TMO_W-1:0] idle_ticks    = '0;
	logic [TMO_W-1:0] total_ticks   = '0;

	result_t     pending_results[$];
	int          error_count = 0;
	int          items_sent  = 0;
	int unsigned cycle_count = 0;
	// set for the last part of the run: no gaps, no stalls
	logic        calm        = 1'b0;

	function automatic logic [7:0] byte_of(logic [DATA_W-1:0] d, int idx);
		return d[DATA_W-1-8*idx -: 8];
	endfunction

	function automatic logic [DATA_W-1:0] random_bytes();
		return {$urandom, $urandom};
	endfunction

	function automatic void expect_result(logic [1:0] kind, logic [ID_W-1:0] id,
			logic [DATA_W-1:0] data, logic [7:0] b, logic [1:0] st,
			logic [LEN_W-1:0] len, logic last);
		pending_results.push_back('{kind, id, data, b, st, len, last});
	endfunction

	// the done result always closes the run
	function automatic void close_run(logic [1:0] st);
		expect_result(KIND_DONE, '0, '0, '0, st, announced_len, 1'b1);
		run_phase = PH_IDLE;
	endfunction

	function automatic void take_frame(logic [ID_W-1:0] fid, logic [DATA_W-1:0] d);
		logic [7:0] pci;
		logic [3:0] ftype;
		int         n;
		pci   = byte_of(d, 0);
		ftype = pci[7:4];
		// any frame on the bus restarts the idle count, even a foreign one
		idle_ticks = '0;
		if (fid != cfg_response_id)
			return;
		if (run_phase == PH_FIRST) begin
			// pid filter applies to the first answer only
			if (byte_of(d, 2) != run_pid && byte_of(d, 2) != PID_ANY)
				return;
			total_ticks = '0;
			if (ftype == TYPE_SF) begin
				n = int'(pci[3:0]);
				if (n > int'(MAX_FRAME_BYTES))
					n = int'(MAX_FRAME_BYTES);
				announced_len = LEN_W'(n);
				for (int i = 0; i < n; i++)
					expect_result(KIND_BYTE, '0, '0, byte_of(d, 1 + i), ST_OK, '0, 1'b0);
				close_run(ST_OK);
			end else if (ftype == TYPE_FF) begin
				announced_len = {pci[3:0], byte_of(d, 1)};
				for (int i = 0; i < int'(FF_BYTES); i++)
					expect_result(KIND_BYTE, '0, '0, byte_of(d, 2 + i), ST_OK, '0, 1'b0);
				expect_result(KIND_TX, cfg_request_id, {PCI_FLOW_CTRL, 56'd0}, '0, ST_OK,
					'0, 1'b0);
				rx_count = LEN_W'(FF_BYTES);
				next_seq = 4'd1;
				if (rx_count >= announced_len)
					close_run(ST_OK);
				else
					run_phase = PH_CONSEC;
			end else begin
				announced_len = '0;
				close_run(ST_TYPE);
			end
		end else begin
			total_ticks = '0;
			if (ftype != TYPE_CF) begin
				close_run(ST_TYPE);
				return;
			end
			if (pci[3:0] != next_seq) begin
				close_run(ST_SEQ);
				return;
			end
			next_seq = next_seq + 4'd1;
			n = int'(announced_len) - int'(rx_count);
			if (n > int'(MAX_FRAME_BYTES))
				n = int'(MAX_FRAME_BYTES);
			for (int i = 0; i < n; i++)
				expect_result(KIND_BYTE, '0, '0, byte_of(d, 1 + i), ST_OK, '0, 1'b0);
			rx_count = rx_count + LEN_W'(n);
			if (rx_count >= announced_len)
				close_run(ST_OK);
		end
	endfunction

	// queues the results that one accepted item causes
	function automatic void predict_item_results(logic [1:0] cmd, logic [7:0] mode,
			logic [7:0] pid, logic [ID_W-1:0] fid, logic [DATA_W-1:0] fdata);
		case (cmd)
			CMD_START: begin
				// a start drops any open run without a done result
				expect_result(KIND_TX, cfg_request_id, {PCI_QUERY, mode, pid, 40'd0}, '0,
					ST_OK, '0, 1'b0);
				run_pid       = pid;
				run_phase     = PH_FIRST;
				next_seq      = '0;
				rx_count      = '0;
				announced_len = '0;
				idle_ticks    = '0;
				total_ticks   = '0;
			end
			CMD_FRAME: begin
				if (run_phase != PH_IDLE)
					take_frame(fid, fdata);
			end
			CMD_TICK: begin
				if (run_phase != PH_IDLE) begin
					// both counters saturate
					if (idle_ticks != '1)
						idle_ticks = idle_ticks + 16'd1;
					if (total_ticks != '1)
						total_ticks = total_ticks + 16'd1;
					if (idle_ticks >= cfg_idle_limit || total_ticks >= cfg_total_limit)
						close_run(ST_TIMEOUT);
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------
	task automatic flag_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic compare_field(string name, logic [DATA_W-1:0] got_v,
			logic [DATA_W-1:0] want_v);
		if (got_v !== want_v)
			flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got_v, want_v));
	endtask

	task automatic check_result();
		result_t got;
		result_t want;
		got = '{res_ch.kind, res_ch.tx_id, res_ch.tx_data, res_ch.payload_byte,
			res_ch.status, res_ch.resp_len, res_ch.last};
		if (pending_results.size() == 0) begin
			flag_mismatch($sformatf("result of kind %0d with nothing expected", got.kind));
			return;
		end
		want = pending_results.pop_front();
		compare_field("kind", DATA_W'(got.kind), DATA_W'(want.kind));
		compare_field("tx_id", DATA_W'(got.tx_id), DATA_W'(want.tx_id));
		compare_field("tx_data", got.tx_data, want.tx_data);
		compare_field("payload_byte", DATA_W'(got.payload_byte), DATA_W'(want.payload_byte));
		compare_field("status", DATA_W'(got.status), DATA_W'(want.status));
		compare_field("resp_len", DATA_W'(got.resp_len), DATA_W'(want.resp_len));
		compare_field("last", DATA_W'(got.last), DATA_W'(want.last));
	endtask

	// values seen here are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			check_result();
	end

	// result side: random stall bursts, none once calm
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// Returns in the time step of the accepting edge with valid still high, so
	// the next call can keep it high; settle() lowers it when the run pauses.
	task automatic transfer_item(logic [1:0] cmd, logic [7:0] mode, logic [7:0] pid,
			logic [ID_W-1:0] fid, logic [DATA_W-1:0] fdata);
		if (!calm && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.cmd        <= cmd;
		item_ch.req_mode   <= mode;
		item_ch.req_pid    <= pid;
		item_ch.frame_id   <= fid;
		item_ch.frame_data <= fdata;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent++;
		predict_item_results(cmd, mode, pid, fid, fdata);
	endtask

	task automatic query(logic [7:0] mode, logic [7:0] pid);
		transfer_item(CMD_START, mode, pid, '0, '0);
	endtask

	task automatic frame(logic [DATA_W-1:0] d);
		transfer_item(CMD_FRAME, '0, '0, cfg_response_id, d);
	endtask

	task automatic tick();
		transfer_item(CMD_TICK, '0, '0, '0, '0);
	endtask

	// waits until every expected result has come and the block has gone quiet
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; only called while settled
	task automatic set_reg(logic [1:0] idx, logic [15:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_REQUEST_ID:    cfg_request_id  = value[ID_W-1:0];
			REG_RESPONSE_ID:   cfg_response_id = value[ID_W-1:0];
			REG_IDLE_TIMEOUT:  cfg_idle_limit  = value;
			REG_TOTAL_TIMEOUT: cfg_total_limit = value;
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Random traffic
	// ------------------------------------------------------------------------
	// a tick, a frame from another id, or a frame whose pid does not match
	task automatic random_disturbance(logic [7:0] pid);
		logic [DATA_W-1:0] d;
		d = random_bytes();
		case ($urandom_range(0, 2))
			0: transfer_item(CMD_TICK, 8'($urandom), 8'($urandom), 11'($urandom), d);
			1: transfer_item(CMD_FRAME, 8'($urandom), 8'($urandom),
				cfg_response_id ^ 11'(1 << $urandom_range(0, ID_W - 1)), d);
			default: begin
				d[47:40] = (pid == 8'hFE) ? 8'h00 : pid + 8'd1;
				transfer_item(CMD_FRAME, 8'($urandom), 8'($urandom), cfg_response_id, d);
			end
		endcase
	endtask

	// one query and its answer: mostly well formed, now and then broken
	task automatic random_query();
		logic [7:0]        mode;
		logic [7:0]        pid;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] d;
		logic [3:0]        seq;
		logic [3:0]        ftype;
		int                shape;
		int                pick;
		int                frames;
		mode = 8'($urandom);
		pid  = 8'($urandom);
		transfer_item(CMD_START, mode, pid, 11'($urandom), random_bytes());
		repeat ($urandom_range(0, 2)) random_disturbance(pid);
		d = random_bytes();
		d[47:40] = ($urandom_range(0, 3) == 0) ? PID_ANY : pid;
		shape = $urandom_range(0, 9);
		if (shape < 4) begin
			d[63:56] = {TYPE_SF, 4'($urandom)};
			transfer_item(CMD_FRAME, 8'($urandom), 8'($urandom), cfg_response_id, d);
		end else if (shape < 9) begin
			// mostly short answers, some long enough to wrap the sequence number
			pick = $urandom_range(0, 19);
			if (pick < 12)
				len = LEN_W'($urandom_range(0, 40));
			else if (pick < 17)
				len = LEN_W'($urandom_range(100, 130));
			else
				len = LEN_W'($urandom);
			d[63:48] = {TYPE_FF, len};
			transfer_item(CMD_FRAME, 8'($urandom), 8'($urandom), cfg_response_id, d);
			seq    = 4'd1;
			frames = 0;
			while (run_phase == PH_CONSEC && frames < 20) begin
				d = random_bytes();
				d[63:56] = {TYPE_CF, seq};
				case ($urandom_range(0, 24))
					0: d[59:56] = seq + 4'($urandom_range(1, 15));
					1: begin
						ftype = 4'($urandom);
						if (ftype == TYPE_CF)
							ftype = 4'hF;
						d[63:60] = ftype;
					end
					2: random_disturbance(pid);
					default: ;
				endcase
				transfer_item(CMD_FRAME, 8'($urandom), 8'($urandom), cfg_response_id, d);
				seq = seq + 4'd1;
				frames++;
			end
		end else begin
			// first answer of a type that cannot open a response
			d[63:60] = 4'($urandom_range(2, 15));
			transfer_item(CMD_FRAME, 8'($urandom), 8'($urandom), cfg_response_id, d);
		end
	endtask

	task automatic random_noise();
		logic [ID_W-1:0] fid;
		fid = ($urandom_range(0, 1) == 0) ? cfg_response_id : 11'($urandom);
		transfer_item(2'($urandom), 8'($urandom), 8'($urandom), fid, random_bytes());
	endtask

	task automatic random_phase(int quota);
		int first;
		first = items_sent;
		while (items_sent - first < quota) begin
			if ($urandom_range(0, 9) < 7)
				random_query();
			else
				random_noise();
		end
		settle();
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_single_frames();
		query(8'h01, 8'h0C);
		frame({TYPE_SF, 4'd4, 56'h41_0C_1A_F8_00_00_00});
		// length nibble above 7 is clamped, pid byte is the wildcard
		query(8'hFF, 8'h00);
		frame({TYPE_SF, 4'hF, 56'hA5_FF_5A_C3_3C_96_69});
		settle();
	endtask

	task automatic test_multi_frames();
		query(8'h09, 8'h02);
		frame({TYPE_FF, 12'd20, 48'h02_01_57_44_30_55});
		frame({TYPE_CF, 4'd1, 56'h5A_5A_39_38_37_36_35});
		frame({TYPE_CF, 4'd2, 56'h34_33_32_31_30_00_FF});
		// first frame covers the whole announced length
		query(8'h01, 8'h0D);
		frame({TYPE_FF, 12'd6, 48'h0D_11_22_33_44_55});
		// longest announced length, then a skipped sequence number
		query(8'h22, 8'hF1);
		frame({TYPE_FF, 12'hFFF, 48'hF1_AA_BB_CC_DD_EE});
		frame({TYPE_CF, 4'd2, 56'h0});
		// flow-control type as the first answer
		query(8'h01, 8'h00);
		frame({TYPE_FC, 4'd0, 56'h0});
		settle();
	endtask

	task automatic test_ignored_items();
		frame({TYPE_SF, 4'd3, 56'h41_0C_00_00_00_00_00});
		tick();
		transfer_item(CMD_UNUSED, 8'hFF, 8'hFF, 11'h7FF, '1);
		query(8'h01, 8'h05);
		frame({TYPE_SF, 4'd3, 56'h41_06_7F_00_00_00_00});
		// restart while the run is still open
		query(8'h01, 8'h0C);
		frame({TYPE_SF, 4'd2, 56'h41_FF_00_00_00_00_00});
		settle();
	endtask

	task automatic test_timeouts();
		set_reg(REG_IDLE_TIMEOUT, 16'd2);
		set_reg(REG_TOTAL_TIMEOUT, 16'd3);
		query(8'h01, 8'h0C);
		tick();
		tick();
		// foreign frames keep the idle count low, the total count runs out
		query(8'h01, 8'h0C);
		tick();
		transfer_item(CMD_FRAME, '0, '0, cfg_response_id ^ 11'h001, '0);
		tick();
		transfer_item(CMD_FRAME, '0, '0, cfg_response_id ^ 11'h400, '0);
		tick();
		settle();
	endtask

	task automatic test_random_traffic();
		// ids at the range ends, longest timeouts
		set_reg(REG_REQUEST_ID, 16'h0000);
		set_reg(REG_RESPONSE_ID, 16'h07FF);
		set_reg(REG_IDLE_TIMEOUT, 16'hFFFF);
		set_reg(REG_TOTAL_TIMEOUT, 16'hFFFF);
		random_phase(50);
		// shortest timeouts: any tick ends the run
		set_reg(REG_REQUEST_ID, 16'h07FF);
		set_reg(REG_RESPONSE_ID, 16'h0000);
		set_reg(REG_IDLE_TIMEOUT, 16'd1);
		set_reg(REG_TOTAL_TIMEOUT, 16'd1);
		random_phase(40);
		set_reg(REG_REQUEST_ID, 16'($urandom_range(0, 2047)));
		set_reg(REG_RESPONSE_ID, 16'($urandom_range(0, 2047)));
		set_reg(REG_IDLE_TIMEOUT, 16'($urandom_range(2, 20)));
		set_reg(REG_TOTAL_TIMEOUT, 16'($urandom_range(3, 40)));
		random_phase(55);
		// back to defaults, full rate on both sides
		calm = 1'b1;
		set_reg(REG_REQUEST_ID, 16'(REQUEST_ID_RST));
		set_reg(REG_RESPONSE_ID, 16'(RESPONSE_ID_RST));
		set_reg(REG_IDLE_TIMEOUT, IDLE_TIMEOUT_RST);
		set_reg(REG_TOTAL_TIMEOUT, TOTAL_TIMEOUT_RST);
		random_phase(55);
	endtask

	initial begin
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		item_ch.valid      <= 1'b0;
		item_ch.cmd        <= CMD_TICK;
		item_ch.req_mode   <= '0;
		item_ch.req_pid    <= '0;
		item_ch.frame_id   <= '0;
		item_ch.frame_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_frames();
		test_multi_frames();
		test_ignored_items();
		test_timeouts();
		test_random_traffic();

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/obdtp_pkg.sv
rtl/core/obdtp_item_if.sv
rtl/core/obdtp_res_if.sv
rtl/core/obd_isotp_request_receiver.sv
rtl/core/obdtp_checker.sv
test/tb.sv
